// File: rtl/deq_pkg.sv
// Package for the double-ended queue: transaction structs, operation and
// status codes, and the command set of the storage cells.
// No dependencies.
package deq_pkg;

  localparam int DEFAULT_DEPTH = 64;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_QUERY      = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [6:0]         occupancy;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_t;

  // Command broadcast to every cell of one chain.
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_SHIFT_IN  = 3'd1,
    CELL_APPEND    = 3'd2,
    CELL_SHIFT_OUT = 3'd3,
    CELL_DROP      = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// File: rtl/deq_cell.sv
// One storage cell of a deque chain: a data word and an occupancy bit.
// Depends on deq_pkg for the cell command struct.
module deq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] left_data,
  input  logic               left_occ,
  input  logic signed [31:0] right_data,
  input  logic               right_occ,
  output logic signed [31:0] data,
  output logic               occ
);
  import deq_pkg::*;

  logic signed [31:0] data_r, data_nxt;
  logic               occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    case (ctl.cmd)
      CELL_HOLD: begin
      end
      CELL_SHIFT_IN: begin
        data_nxt = left_data;
        occ_nxt  = left_occ;
      end
      CELL_APPEND: begin
        // Only the first free cell takes the new word.
        if (left_occ && !occ_r) begin
          data_nxt = ctl.value;
        end
        occ_nxt = left_occ;
      end
      CELL_SHIFT_OUT: begin
        data_nxt = right_data;
        occ_nxt  = right_occ;
      end
      CELL_DROP: begin
        occ_nxt = right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign data = data_r;
  assign occ  = occ_r;

endmodule

// File: rtl/deq_chain.sv
// A row of DEPTH cells that shifts as a whole; cell 0 is the head.
// Depends on deq_pkg and deq_cell.
module deq_chain #(
  parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::cell_ctl_t ctl,
  output logic signed [31:0] head_data,
  output logic               head_occ,
  output logic               tail_occ
);
  import deq_pkg::*;

  logic signed [31:0] cell_data [DEPTH];
  logic               cell_occ  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] l_data, r_data;
    logic               l_occ, r_occ;

    if (i == 0) begin : g_first
      assign l_data = ctl.value;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i])
    );
  end

  assign head_data = cell_data[0];
  assign head_occ  = cell_occ[0];
  assign tail_occ  = cell_occ[DEPTH-1];

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
// Depends on deq_pkg and deq_chain (which uses deq_cell).
//
// Usage: each input transaction on in_valid/in_ready carries a selector
// (push front, push back, pop front, pop back, or query) and a value to push.
// Every input transaction produces exactly one output transaction on
// out_valid/out_ready with the popped value, a status code, the occupancy,
// and the front and back entries as they stand after the operation.
// A push on a full queue or a pop on an empty one is refused with a status
// code and leaves the contents alone. Unused selector codes act as queries.
//
// The result is registered: it is in the output register at the edge after
// acceptance. Throughput is one transaction per cycle unless the receiver
// stalls, set by the single shift step of the cell chains. While it stalls,
// the finished result is held and in_ready stays low; a new transaction is
// taken in the same cycle that the waiting result leaves.
// Reset (synchronous, active low) empties the queue and drops any pending
// result. Storage words are not cleared; only occupancy bits are.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::out_t out_data
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Two chains hold the same contents. The front chain keeps the first
  // entry in its cell 0, the back chain keeps the last entry in its cell 0
  // (reversed order). Each end operation is then a shift at the head of
  // one chain and a write or drop at the far end of the other, so every
  // cell only ever looks at its two neighbors.
  cell_ctl_t          f_ctl, b_ctl;
  logic signed [31:0] f_head, b_head;
  logic               f_head_occ, b_head_occ;
  logic               f_tail_occ, b_tail_occ;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] popped_r, popped_nxt;
  logic [1:0]         status_r, status_nxt;

  logic               accept;
  logic               is_push, is_pop;
  logic               full, empty;
  logic               do_op;
  logic [31:0]        count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // The front chain's occupancy bits decide empty and full; the back
  // chain carries the same bits and its tail is checked against them.
  assign full  = f_tail_occ;
  assign empty = !f_head_occ;

  always_comb begin
    is_push    = in_data.func inside {FUNC_PUSH_FRONT, FUNC_PUSH_BACK};
    is_pop     = in_data.func inside {FUNC_POP_FRONT, FUNC_POP_BACK};
    status_nxt = STATUS_OK;
    if (is_push && full) begin
      status_nxt = STATUS_FULL;
    end else if (is_pop && empty) begin
      status_nxt = STATUS_EMPTY;
    end
    do_op = accept && (status_nxt == STATUS_OK);

    f_ctl.cmd   = CELL_HOLD;
    b_ctl.cmd   = CELL_HOLD;
    f_ctl.value = in_data.value_in;
    b_ctl.value = in_data.value_in;
    popped_nxt  = '0;
    count_nxt   = count_r;

    if (do_op) begin
      case (in_data.func)
        FUNC_PUSH_FRONT: begin
          f_ctl.cmd = CELL_SHIFT_IN;
          b_ctl.cmd = CELL_APPEND;
          count_nxt = count_r + CNT_W'(1);
        end
        FUNC_PUSH_BACK: begin
          f_ctl.cmd = CELL_APPEND;
          b_ctl.cmd = CELL_SHIFT_IN;
          count_nxt = count_r + CNT_W'(1);
        end
        FUNC_POP_FRONT: begin
          f_ctl.cmd  = CELL_SHIFT_OUT;
          b_ctl.cmd  = CELL_DROP;
          popped_nxt = f_head;
          count_nxt  = count_r - CNT_W'(1);
        end
        FUNC_POP_BACK: begin
          f_ctl.cmd  = CELL_DROP;
          b_ctl.cmd  = CELL_SHIFT_OUT;
          popped_nxt = b_head;
          count_nxt  = count_r - CNT_W'(1);
        end
        default: begin
          // Query and unused selector codes change nothing.
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  deq_chain #(.DEPTH(DEPTH)) u_front_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (f_ctl),
    .head_data (f_head),
    .head_occ  (f_head_occ),
    .tail_occ  (f_tail_occ)
  );

  deq_chain #(.DEPTH(DEPTH)) u_back_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (b_ctl),
    .head_data (b_head),
    .head_occ  (b_head_occ),
    .tail_occ  (b_tail_occ)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; only loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  // The chain heads change only on acceptance, which happens only while no
  // result waits or as it leaves, so they are read straight into the result.
  assign count_ext             = 32'(count_r);
  assign out_valid             = out_valid_r;
  assign out_data.popped_value = popped_r;
  assign out_data.status       = status_r;
  assign out_data.occupancy    = count_ext[6:0];
  assign out_data.front_value  = (count_r != '0) ? f_head : 32'sd0;
  assign out_data.back_value   = (count_r != '0) ? b_head : 32'sd0;

  // With a single entry both chain heads hold the same word.
  a_single_entry_heads: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(1)) |-> (f_head == b_head))
    else $error("chain heads disagree with one entry stored");

  // Occupancy bits of both chains track the entry counter.
  a_occ_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (f_head_occ == (count_r != '0)) && (b_head_occ == f_head_occ) &&
    (b_tail_occ == f_tail_occ) && (f_tail_occ == (count_r == CNT_W'(DEPTH))))
    else $error("occupancy bits out of step with entry count");

  // An accepted push that is not refused grows the queue by one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted push did not add an entry");

  // A refused operation leaves the count unchanged.
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status_nxt != STATUS_OK)) |=> $stable(count_r))
    else $error("refused operation changed the entry count");

endmodule

// File: tb/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: a directed list of rows,
// then random push/pop bursts under several idle and stall patterns.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int QDEPTH    = DEFAULT_DEPTH;
  localparam int LONG_HOLD = 300;

  // One row of stimulus. When typed is set, want is the result read straight
  // off the spec; otherwise the predictor supplies the expected result.
  typedef struct packed {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  typedef enum int {BURST_FILL, BURST_MIXED, BURST_DRAIN} burst_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // Side information that travels with the item currently offered.
  bit   row_typed = 1'b0;
  out_t row_want  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_epoch     = 0;
  int seen_epoch     = 0;
  int hold_left      = 0;
  int mismatch_count = 0;

  // Predictor state: the ring contents, the position of the first entry and
  // the number of stored entries.
  logic signed [31:0] ring_mem [QDEPTH];
  int ring_head;
  int ring_fill;

  out_t awaited_results [$];

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one operation to the predicted deque and returns its result.
  // Refused pushes and pops leave the ring untouched; unused selectors are
  // treated as queries.
  function automatic out_t deque_apply(in_t item);
    out_t r;
    r = '0;
    r.status = STATUS_OK;
    case (item.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (ring_fill >= QDEPTH) begin
          r.status = STATUS_FULL;
        end else if (item.func == FUNC_PUSH_FRONT) begin
          ring_head = (ring_head + QDEPTH - 1) % QDEPTH;
          ring_mem[ring_head] = item.value_in;
          ring_fill++;
        end else begin
          ring_mem[(ring_head + ring_fill) % QDEPTH] = item.value_in;
          ring_fill++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (ring_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else if (item.func == FUNC_POP_FRONT) begin
          r.popped_value = ring_mem[ring_head];
          ring_head = (ring_head + 1) % QDEPTH;
          ring_fill--;
        end else begin
          r.popped_value = ring_mem[(ring_head + ring_fill - 1) % QDEPTH];
          ring_fill--;
        end
      end
      default: ;
    endcase
    r.occupancy = 7'(ring_fill);
    if (ring_fill != 0) begin
      r.front_value = ring_mem[ring_head];
      r.back_value  = ring_mem[(ring_head + ring_fill - 1) % QDEPTH];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Monitor: the result leaving at this edge is checked before the item
  // entering at this edge is predicted, so the two never get mixed up.
  always @(posedge clk) begin
    out_t want;
    out_t pred;
    if (!rst_n) begin
      ring_head = 0;
      ring_fill = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.occupancy, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.popped_value != want.popped_value)
            report_mismatch("popped_value", out_data.popped_value, want.popped_value);
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.occupancy != want.occupancy)
            report_mismatch("occupancy", out_data.occupancy, want.occupancy);
          if (out_data.front_value != want.front_value)
            report_mismatch("front_value", out_data.front_value, want.front_value);
          if (out_data.back_value != want.back_value)
            report_mismatch("back_value", out_data.back_value, want.back_value);
        end
      end
      if (in_valid && in_ready) begin
        pred = deque_apply(in_data);
        awaited_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // Receiver. A change of hold_epoch starts a long hold-off that this process
  // counts down on its own; otherwise it stalls at the current random rate.
  always @(posedge clk) begin
    if (hold_epoch != seen_epoch) begin
      seen_epoch <= hold_epoch;
      hold_left  <= LONG_HOLD;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic row_t typed_row(logic [2:0] f, logic signed [31:0] v,
                                     logic signed [31:0] pv, logic [1:0] st,
                                     logic [6:0] occ, logic signed [31:0] fv,
                                     logic signed [31:0] bv);
    row_t r;
    r.item.func         = f;
    r.item.value_in     = v;
    r.typed             = 1'b1;
    r.want.popped_value = pv;
    r.want.status       = st;
    r.want.occupancy    = occ;
    r.want.front_value  = fv;
    r.want.back_value   = bv;
    return r;
  endfunction

  function automatic row_t checked_row(logic [2:0] f, logic signed [31:0] v);
    row_t r;
    r = '0;
    r.item.func     = f;
    r.item.value_in = v;
    return r;
  endfunction

  // Values lean toward the extremes now and then; otherwise every bit is random.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Fill bursts are mostly pushes at either end, drain bursts mostly pops;
  // both carry some query noise. Mixed bursts use every selector code.
  function automatic row_t random_row(burst_t kind);
    logic [2:0] f;
    int pick;
    pick = $urandom_range(99);
    case (kind)
      BURST_FILL:  f = (pick < 90) ? 3'($urandom_range(1)) : 3'($urandom_range(4, 7));
      BURST_DRAIN: f = (pick < 90) ? 3'(2 + $urandom_range(1)) : 3'($urandom_range(4, 7));
      default: begin
        if (pick < 36)      f = 3'($urandom_range(1));
        else if (pick < 72) f = 3'(2 + $urandom_range(1));
        else                f = 3'($urandom_range(4, 7));
      end
    endcase
    return checked_row(f, pick_value());
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  // Valid is lowered only when an idle gap is taken, so back-to-back items
  // keep it high without a glitch.
  task automatic offer(row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= r.item;
    row_typed <= r.typed;
    row_want  <= r.want;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Cycles fill, mixed and drain bursts. A fill always follows a drain, so the
  // ring runs into full and empty again and again with refused operations.
  // The last burst is cut short so that a phase sends exactly n items.
  task automatic run_phase(int n);
    int sent;
    int k;
    int len;
    burst_t kind;
    sent = 0;
    k = 0;
    while (sent < n) begin
      kind = (k % 3 == 0) ? BURST_FILL : (k % 3 == 1) ? BURST_MIXED : BURST_DRAIN;
      len = (kind == BURST_MIXED) ? $urandom_range(20, 60) : $urandom_range(72, 80);
      if (len > n - sent) len = n - sent;
      repeat (len) offer(random_row(kind));
      sent += len;
      k++;
    end
  endtask

  initial begin
    row_t directed_rows [$];

    // After reset, on the empty ring, at the extremes, and back to empty.
    directed_rows.push_back(typed_row(FUNC_QUERY, 0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(typed_row(FUNC_POP_FRONT, 0, 0, STATUS_EMPTY, 0, 0, 0));
    directed_rows.push_back(typed_row(FUNC_POP_BACK, -1, 0, STATUS_EMPTY, 0, 0, 0));
    directed_rows.push_back(typed_row(3'd5, 32'sh7fffffff, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(typed_row(3'd6, -1, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(typed_row(3'd7, 32'sh80000000, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(typed_row(FUNC_PUSH_FRONT, 32'sh7fffffff, 0, STATUS_OK, 1,
                                      32'sh7fffffff, 32'sh7fffffff));
    directed_rows.push_back(typed_row(FUNC_PUSH_BACK, 32'sh80000000, 0, STATUS_OK, 2,
                                      32'sh7fffffff, 32'sh80000000));
    directed_rows.push_back(checked_row(FUNC_PUSH_FRONT, 0));
    directed_rows.push_back(checked_row(FUNC_PUSH_BACK, -1));
    directed_rows.push_back(checked_row(FUNC_QUERY, 12345));
    directed_rows.push_back(checked_row(3'd5, 32'sh55555555));
    directed_rows.push_back(checked_row(FUNC_POP_FRONT, 32'shaaaaaaaa));
    directed_rows.push_back(checked_row(FUNC_POP_BACK, 0));
    directed_rows.push_back(checked_row(FUNC_PUSH_BACK, 1));
    directed_rows.push_back(checked_row(FUNC_POP_FRONT, 0));
    directed_rows.push_back(checked_row(FUNC_POP_FRONT, 0));
    directed_rows.push_back(checked_row(FUNC_POP_BACK, 0));
    directed_rows.push_back(typed_row(FUNC_POP_BACK, 7, 0, STATUS_EMPTY, 0, 0, 0));
    directed_rows.push_back(typed_row(FUNC_POP_FRONT, 0, 0, STATUS_EMPTY, 0, 0, 0));
    directed_rows.push_back(typed_row(FUNC_PUSH_BACK, -1, 0, STATUS_OK, 1, -1, -1));
    directed_rows.push_back(typed_row(FUNC_POP_FRONT, 0, -1, STATUS_OK, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i]);

    set_idling(0, 0);
    run_phase(400);

    // Long receiver hold-off while the sender keeps offering: the held result
    // blocks the output and in_ready must drop until it drains.
    hold_epoch <= hold_epoch + 1;
    repeat (80) offer(random_row(BURST_MIXED));

    set_idling(51, 0);
    run_phase(400);
    set_idling(0, 51);
    run_phase(400);
    set_idling(32, 32);
    run_phase(400);

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_chain.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
